// ----- rtl/heightmap_vertex_normals_defines.svh -----
// Assertion macros shared by the heightmap vertex normal RTL.
`ifndef HEIGHTMAP_VERTEX_NORMALS_DEFINES_SVH
`define HEIGHTMAP_VERTEX_NORMALS_DEFINES_SVH
`ifndef SYNTHESIS
`define HVN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HVN_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HVN_ASSERT(lbl, clk, rst, prop, msg)
`define HVN_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/hvn_pkg.sv -----
// Shared constants and types of the heightmap vertex normal block.
`default_nettype none
package hvn_pkg;
   localparam int GRID_SIZE  = 32;
   localparam int COL_W      = 6;
   localparam int H_W        = 16;
   localparam int MEM_AW     = COL_W + 1;
   localparam int MEM_DEPTH  = 2 ** MEM_AW;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 104;

   localparam logic       REG_STEP   = 1'b0;
   localparam logic       REG_SCALE  = 1'b1;
   localparam logic [9:0] STEP_RESET  = 10'd100;
   localparam logic [7:0] SCALE_RESET = 8'd15;

   typedef struct packed {
      logic [9:0] step;
      logic [7:0] scale;
   } cfg_type;
endpackage
`default_nettype wire

// ----- rtl/hvn_row_mem.sv -----
// Two-row sample store: one write port and one registered read port.
`default_nettype none
module hvn_row_mem (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [hvn_pkg::MEM_AW-1:0] waddr,
   input  wire logic [hvn_pkg::H_W-1:0]    wdata,
   input  wire logic                      re,
   input  wire logic [hvn_pkg::MEM_AW-1:0] raddr,
   output logic      [hvn_pkg::H_W-1:0]    rdata
);
   import hvn_pkg::*;

   logic [H_W-1:0] mem_ff [0:MEM_DEPTH-1];
   logic [H_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- rtl/hvn_norm.sv -----
// Iterative normaliser: one restoring divide bit, then one square-root bit, per cycle.
`default_nettype none
module hvn_norm (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] mag_sq,
   input  wire logic [32:0] sum_sq,
   output logic             busy,
   output logic             done,
   output logic [15:0]      k
);
   import hvn_pkg::*;

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_DIV  = 2'd1;
   localparam logic [1:0] U_SQRT = 2'd2;
   localparam logic [1:0] U_DONE = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] div_ff, div_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] bit_ff, bit_in;
   logic [33:0] rem2;
   logic        dge;
   logic [32:0] ssum;
   logic        sge;
   logic [16:0] kp;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      rem2     = {rem_ff, 1'b0};
      dge      = rem2 >= {1'b0, div_ff};
      ssum     = {1'b0, res_ff} + {1'b0, bit_ff};
      sge      = {1'b0, quo_ff} >= ssum;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               rem_in   = {1'b0, mag_sq};
               div_in   = sum_sq;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            rem_in = dge ? 33'(rem2 - {1'b0, div_ff}) : rem2[32:0];
            quo_in = {quo_ff[30:0], dge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               res_in   = '0;
               bit_in   = 32'h4000_0000;
               cnt_in   = '0;
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            if (sge) begin
               quo_in = quo_ff - ssum[31:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               state_in = U_DONE;
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign kp   = {1'b0, res_ff[15:0]} + 17'd1;
   assign k    = kp[16:1];
   assign busy = state_ff != U_IDLE;
   assign done = state_ff == U_DONE;
endmodule
`default_nettype wire

// ----- rtl/hvn_csr.sv -----
// Configuration registers behind the APB-style port.
`default_nettype none
module hvn_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [hvn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [hvn_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [hvn_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready,
   output hvn_pkg::cfg_type                   cfg
);
   import hvn_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;
   logic    idx;

   assign idx = csr_paddr[2];
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_STEP:  cfg_in.step  = csr_pwdata[9:0];
            REG_SCALE: cfg_in.scale = csr_pwdata[7:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step  <= STEP_RESET;
         cfg_ff.scale <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_STEP:  csr_prdata = {22'd0, cfg_ff.step};
         REG_SCALE: csr_prdata = {24'd0, cfg_ff.scale};
         default:   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;
endmodule
`default_nettype wire

// ----- rtl/heightmap_vertex_normals.sv -----
// A new sample is taken only once the block is through with the last one, and the output can stall it;
// the final sample of the grid blocks the input until the last row has been flushed.
// Each vertex runs its three normal components in turn through the one shared normaliser.
// Reset clears the counters, the controller, the output valid and the configuration registers;
// the data registers and the row store are not cleared.
`default_nettype none
`include "heightmap_vertex_normals_defines.svh"
module heightmap_vertex_normals (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [hvn_pkg::REQ_DATA_W-1:0] req_tdata,   // [15:0] height
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [15:0] pos_x, [39:16] pos_y, [55:40] pos_z, [71:56] normal_x,
   // [86:72] normal_y, [102:87] normal_z, [103] zero
   output logic      [hvn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [hvn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [hvn_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [hvn_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);
   import hvn_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_WRITE  = 4'd2;
   localparam logic [3:0] S_DIFF   = 4'd3;
   localparam logic [3:0] S_SQ     = 4'd4;
   localparam logic [3:0] S_SUM    = 4'd5;
   localparam logic [3:0] S_NSTART = 4'd6;
   localparam logic [3:0] S_NWAIT  = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;
   localparam logic [3:0] S_FIN    = 4'd9;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_SIZE - 1);

   cfg_type cfg;

   logic [3:0]       state_ff, state_in;
   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [COL_W-1:0] row_cnt_ff, row_cnt_in;
   logic [COL_W-1:0] r_ff, c_ff, x_ff;
   logic             flush_ff, vert_ff, mode_flush_ff;
   logic [2:0]       rd_idx_ff;
   logic [1:0]       comp_ff;
   logic signed [H_W-1:0] h_ff, ce_ff, le_ff, ri_ff, up_ff;
   logic [15:0]      mx_ff, mz_ff;
   logic             nx_neg_ff, nz_neg_ff;
   logic [31:0]      dx2_ff, dz2_ff;
   logic [32:0]      s_ff;
   logic [15:0]      posx_ff, posz_ff;
   logic [23:0]      posy_ff;
   logic [15:0]      kx_ff, ky_ff, kz_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic             req_accept;
   logic             end_grid;
   logic [COL_W-1:0] vcol, vrow;
   logic             nb;
   logic             mem_we, mem_re;
   logic [MEM_AW-1:0] mem_waddr, mem_raddr;
   logic [H_W-1:0]   mem_rdata;
   logic signed [H_W-1:0] le_v, ri_v, up_v, dn_v;
   logic signed [16:0] dx_w, dz_w;
   logic [16:0]      ndx, ndz;
   logic [15:0]      posx_w, posz_w;
   logic signed [24:0] posy_w;
   logic             norm_start, norm_busy, norm_done;
   logic [15:0]      norm_k;
   logic [31:0]      norm_mag;
   logic             out_load, out_last;
   logic [15:0]      nx_o, nz_o;
   logic [14:0]      ny_o;

   hvn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hvn_row_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (h_ff),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   hvn_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .mag_sq (norm_mag),
      .sum_sq (s_ff),
      .busy   (norm_busy),
      .done   (norm_done),
      .k      (norm_k)
   );

   assign req_tready = state_ff == S_IDLE;
   assign req_accept = req_tvalid & req_tready;
   assign end_grid   = (col_cnt_ff == LAST_COL) && (row_cnt_ff == LAST_COL);

   assign vcol = mode_flush_ff ? x_ff : c_ff;
   assign vrow = mode_flush_ff ? r_ff : r_ff - COL_W'(1);
   assign nb   = mode_flush_ff ? r_ff[0] : ~r_ff[0];

   assign mem_we    = state_ff == S_WRITE;
   assign mem_waddr = {r_ff[0], c_ff};
   assign mem_re    = (state_ff == S_READ) && (rd_idx_ff < 3'd4);

   always_comb begin
      case (rd_idx_ff)
         3'd0:    mem_raddr = {nb, vcol};
         3'd1:    mem_raddr = {nb, vcol - COL_W'(1)};
         3'd2:    mem_raddr = {nb, vcol + COL_W'(1)};
         default: mem_raddr = {~nb, vcol};
      endcase
   end

   assign le_v = (vcol == '0) ? ce_ff : le_ff;
   assign ri_v = (vcol == LAST_COL) ? ce_ff : ri_ff;
   assign up_v = (!mode_flush_ff && r_ff == COL_W'(1)) ? ce_ff : up_ff;
   assign dn_v = mode_flush_ff ? ce_ff : h_ff;
   assign dx_w = {le_v[15], le_v} - {ri_v[15], ri_v};
   assign dz_w = {dn_v[15], dn_v} - {up_v[15], up_v};
   assign ndx  = ~dx_w + 17'd1;
   assign ndz  = ~dz_w + 17'd1;

   assign posx_w = {10'd0, vcol} * {6'd0, cfg.step};
   assign posz_w = {10'd0, vrow} * {6'd0, cfg.step};
   assign posy_w = ce_ff * $signed({1'b0, cfg.scale});

   assign norm_start = state_ff == S_NSTART;
   always_comb begin
      case (comp_ff)
         COMP_X:  norm_mag = dx2_ff;
         COMP_Y:  norm_mag = 32'd4;
         COMP_Z:  norm_mag = dz2_ff;
         default: norm_mag = '0;
      endcase
   end

   assign nx_o = nx_neg_ff ? 16'(~kx_ff + 16'd1) : (kx_ff[15] ? 16'h7FFF : kx_ff);
   assign nz_o = nz_neg_ff ? 16'(~kz_ff + 16'd1) : (kz_ff[15] ? 16'h7FFF : kz_ff);
   assign ny_o = ky_ff[15] ? 15'h7FFF : ky_ff[14:0];

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign out_last = mode_flush_ff && (x_ff == LAST_COL);
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_tready);

   always_comb begin
      state_in   = state_ff;
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (req_accept) begin
         if (col_cnt_ff == LAST_COL) begin
            col_cnt_in = '0;
            row_cnt_in = end_grid ? '0 : row_cnt_ff + COL_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + COL_W'(1);
         end
      end
      case (state_ff)
         S_IDLE:   if (req_accept) state_in = (row_cnt_ff != '0) ? S_READ : S_WRITE;
         S_READ:   if (rd_idx_ff == 3'd4) state_in = mode_flush_ff ? S_DIFF : S_WRITE;
         S_WRITE:  state_in = vert_ff ? S_DIFF : S_FIN;
         S_DIFF:   state_in = S_SQ;
         S_SQ:     state_in = S_SUM;
         S_SUM:    state_in = S_NSTART;
         S_NSTART: state_in = S_NWAIT;
         S_NWAIT: begin
            if (norm_done) begin
               state_in = (comp_ff == COMP_Z) ? S_OUT : S_NSTART;
            end
         end
         S_OUT: begin
            if (out_load) begin
               if (!mode_flush_ff) begin
                  state_in = S_FIN;
               end else begin
                  state_in = (x_ff == LAST_COL) ? S_IDLE : S_READ;
               end
            end
         end
         S_FIN:    state_in = flush_ff ? S_READ : S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         rd_idx_ff     <= '0;
         comp_ff       <= COMP_X;
         mode_flush_ff <= 1'b0;
         flush_ff      <= 1'b0;
         vert_ff       <= 1'b0;
         x_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            flush_ff      <= end_grid;
            vert_ff       <= row_cnt_ff != '0;
            mode_flush_ff <= 1'b0;
         end
         if (state_ff == S_READ) begin
            rd_idx_ff <= (rd_idx_ff == 3'd4) ? 3'd0 : rd_idx_ff + 3'd1;
         end
         if (state_ff == S_SUM) begin
            comp_ff <= COMP_X;
         end else if (state_ff == S_NWAIT && norm_done) begin
            comp_ff <= comp_ff + 2'd1;
         end
         if (state_ff == S_FIN && flush_ff) begin
            mode_flush_ff <= 1'b1;
            x_ff          <= '0;
         end
         if (out_load && mode_flush_ff) begin
            x_ff <= x_ff + COL_W'(1);
            if (x_ff == LAST_COL) begin
               mode_flush_ff <= 1'b0;
               flush_ff      <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         h_ff <= req_tdata[15:0];
         r_ff <= row_cnt_ff;
         c_ff <= col_cnt_ff;
      end
      if (state_ff == S_READ) begin
         case (rd_idx_ff)
            3'd1:    ce_ff <= mem_rdata;
            3'd2:    le_ff <= mem_rdata;
            3'd3:    ri_ff <= mem_rdata;
            3'd4:    up_ff <= mem_rdata;
            default: ce_ff <= ce_ff;
         endcase
      end
      if (state_ff == S_DIFF) begin
         mx_ff     <= dx_w[16] ? ndx[15:0] : dx_w[15:0];
         mz_ff     <= dz_w[16] ? ndz[15:0] : dz_w[15:0];
         nx_neg_ff <= dx_w[16];
         nz_neg_ff <= dz_w[16];
      end
      if (state_ff == S_SQ) begin
         dx2_ff  <= mx_ff * mx_ff;
         dz2_ff  <= mz_ff * mz_ff;
         posx_ff <= posx_w;
         posz_ff <= posz_w;
         posy_ff <= posy_w[23:0];
      end
      if (state_ff == S_SUM) begin
         s_ff <= {1'b0, dx2_ff} + {1'b0, dz2_ff} + 33'd4;
      end
      if (state_ff == S_NWAIT && norm_done) begin
         case (comp_ff)
            COMP_X:  kx_ff <= norm_k;
            COMP_Y:  ky_ff <= norm_k;
            default: kz_ff <= norm_k;
         endcase
      end
      if (out_load) begin
         rsp_data_ff <= {1'b0, nz_o, ny_o, nx_o, posz_ff, posy_ff, posx_ff};
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HVN_ASSERT(a_grid_wrap, clock, reset, (req_accept && end_grid) |=> (col_cnt_ff == '0 && row_cnt_ff == '0), "Counters did not wrap after the final sample.")
   `HVN_ASSERT(a_norm_free, clock, reset, norm_start |-> !norm_busy, "Normaliser started while busy.")
   `HVN_ASSERT(a_last_corner, clock, reset, (out_load && out_last) |-> (vcol == LAST_COL && vrow == LAST_COL), "Last vertex flagged away from the grid corner.")
   `HVN_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "Block not idle after reset.")
endmodule
`default_nettype wire

// ----- dv/tb_heightmap_vertex_normals.sv -----
// Self-checking testbench for the heightmap vertex normal block.
`timescale 1ns / 100ps
module tb_heightmap_vertex_normals;
   import hvn_pkg::*;

   localparam int CYCLE_LIMIT = 12000000;
   localparam int SETTLE      = 400;

   typedef struct {
      logic [15:0] pos_x;
      logic [23:0] pos_y;
      logic [15:0] pos_z;
      logic [15:0] normal_x;
      logic [14:0] normal_y;
      logic [15:0] normal_z;
      logic        last_vertex;
   } vertex_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [15:0] height
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] pos_x, [39:16] pos_y, [55:40] pos_z, [71:56] normal_x,
   // [86:72] normal_y, [102:87] normal_z, [103] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   vertex_type       pending_vertices[$];
   logic signed [15:0] line_buf[2][64];
   int unsigned      col_idx, row_idx;
   logic [9:0]       step_reg;
   logic [7:0]       scale_reg;
   int unsigned      burst_left;
   int unsigned      cycle_count;
   int unsigned      stall_mode;
   bit               failed;

   heightmap_vertex_normals uut (.*);

   always #6 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned m);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > m) bitv >>= 2;
      while (bitv != 0) begin
         if (m >= res + bitv) begin
            m   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_component(longint c, longint unsigned s);
      longint unsigned mag, k;
      mag = (c < 0) ? -c : c;
      k   = (int_sqrt(((mag * mag) << 32) / s) + 1) >> 1;
      if (c < 0) return 16'(-k);
      if (k > 32767) k = 32767;
      return 16'(k);
   endfunction

   function automatic vertex_type make_vertex(int unsigned r, int unsigned c, longint ce,
                                              longint le, longint ri, longint up,
                                              longint dn, bit last);
      vertex_type v;
      longint dx, dz;
      longint unsigned s;
      logic [15:0] ny;
      dx = le - ri;
      dz = dn - up;
      s  = dx * dx + 4 + dz * dz;
      v.pos_x       = 16'(c * step_reg);
      v.pos_y       = 24'(ce * longint'(scale_reg));
      v.pos_z       = 16'(r * step_reg);
      v.normal_x    = unit_component(dx, s);
      ny            = unit_component(2, s);
      v.normal_y    = ny[14:0];
      v.normal_z    = unit_component(dz, s);
      v.last_vertex = last;
      return v;
   endfunction

   function automatic void queue_vertex(vertex_type v);
      pending_vertices.insert(pending_vertices.size(), v);
   endfunction

   // Work out the vertices released by one accepted height sample.
   task automatic predict_vertices(logic signed [15:0] h);
      int unsigned cur, prv;
      longint ce, le, ri, up;
      cur = row_idx & 1;
      prv = cur ^ 1;
      if (row_idx > 0) begin
         ce = line_buf[prv][col_idx];
         le = (col_idx > 0) ? line_buf[prv][col_idx-1] : ce;
         ri = (col_idx < GRID_SIZE-1) ? line_buf[prv][col_idx+1] : ce;
         up = (row_idx > 1) ? line_buf[cur][col_idx] : ce;
         queue_vertex(make_vertex(row_idx-1, col_idx, ce, le, ri, up, h, 0));
      end
      line_buf[cur][col_idx] = h;
      if (col_idx == GRID_SIZE-1 && row_idx == GRID_SIZE-1) begin
         for (int x = 0; x < GRID_SIZE; x++) begin
            ce = line_buf[cur][x];
            le = (x > 0) ? line_buf[cur][x-1] : ce;
            ri = (x < GRID_SIZE-1) ? line_buf[cur][x+1] : ce;
            up = line_buf[prv][x];
            queue_vertex(make_vertex(row_idx, x, ce, le, ri, up, ce, x == GRID_SIZE-1));
         end
         col_idx = 0;
         row_idx = 0;
      end else if (col_idx == GRID_SIZE-1) begin
         col_idx = 0;
         row_idx++;
      end else begin
         col_idx++;
      end
   endtask

   task automatic send_height(logic signed [15:0] h);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tdata  = h;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_vertices(h);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(logic idx, logic [31:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (idx == REG_STEP) step_reg = value[9:0];
      else scale_reg = value[7:0];
      if (csr_prdata != ((idx == REG_STEP) ? 32'(step_reg) : 32'(scale_reg))) begin
         $display("%0t register %0d expected %0h actual %0h", $time, idx,
                  (idx == REG_STEP) ? 32'(step_reg) : 32'(scale_reg), csr_prdata);
         failed = 1'b1;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic signed [15:0] edge_sample(int r, int c);
      case ((r * 7 + c * 3) % 6)
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return -16'sd1;
         4: return 16'sd1;
         default: return ((r + c) % 2) ? 16'sh5555 : 16'shAAAA;
      endcase
   endfunction

   // Rows are flat, smooth or full range so that both saturated and steep normals appear.
   task automatic send_random_rows(int first, int last);
      int unsigned mode;
      logic signed [15:0] base;
      for (int r = first; r <= last; r++) begin
         mode = $urandom_range(0, 3);
         base = 16'($urandom);
         for (int c = 0; c < GRID_SIZE; c++) begin
            case (mode)
               0: send_height(base);
               1: send_height(16'(base + $signed(16'($urandom_range(0, 8))) - 4));
               default: send_height(16'($urandom));
            endcase
         end
      end
   endtask

   task automatic test_edge_values();
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < GRID_SIZE; c++) send_height(edge_sample(r, c));
      wait_idle();
      write_register(REG_STEP, 32'd1023);
      write_register(REG_SCALE, 32'd255);
      for (int r = 4; r < 7; r++)
         for (int c = 0; c < GRID_SIZE; c++) send_height(edge_sample(r, c));
      wait_idle();
   endtask

   task automatic test_random_grid();
      write_register(REG_STEP, 32'd0);
      write_register(REG_SCALE, 32'd0);
      send_random_rows(7, 9);
      wait_idle();
      write_register(REG_STEP, $urandom);
      write_register(REG_SCALE, $urandom);
      send_random_rows(10, 12);
      wait_idle();
   endtask

   always @(negedge clock) begin
      if (cycle_count % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= (cycle_count % 8) < 3;
         default: rsp_tready <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin
      vertex_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vertices.size() == 0) begin
            $display("%0t unexpected vertex actual %0h last %0b", $time, rsp_tdata, rsp_tlast);
            failed = 1'b1;
         end else begin
            e = pending_vertices.pop_front();
            if (rsp_tdata[15:0] !== e.pos_x || rsp_tdata[39:16] !== e.pos_y ||
                rsp_tdata[55:40] !== e.pos_z || rsp_tdata[71:56] !== e.normal_x ||
                rsp_tdata[86:72] !== e.normal_y || rsp_tdata[102:87] !== e.normal_z ||
                rsp_tdata[103] !== 1'b0 || rsp_tlast !== e.last_vertex) begin
               $display("%0t vertex mismatch expected %h %h %h %h %h %h %b actual %h %b",
                        $time, e.pos_x, e.pos_y, e.pos_z, e.normal_x, e.normal_y,
                        e.normal_z, e.last_vertex, rsp_tdata, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      stall_mode  = 0;
      burst_left  = 0;
      failed      = 1'b0;
      col_idx     = 0;
      row_idx     = 0;
      step_reg    = STEP_RESET;
      scale_reg   = SCALE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_edge_values();
      test_random_grid();
      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
